// ----- sv/lkst_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_pkg: shared types and constants of the LRU keyed slot table
// Holds the slot count, the transaction structs and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lkst_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    FUNC_LOOKUP_KEY  = 2'd0,
    FUNC_LOOKUP_PATH = 2'd1,
    FUNC_SAVE        = 2'd2,
    FUNC_CLEAR       = 2'd3
  } func_e;

  typedef struct packed {
    func_e       func;
    logic [63:0] fingerprint;
    logic [31:0] path_hash;
    logic        path_empty;
    logic [31:0] offset;
    logic [6:0]  percent;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_index;
    logic [63:0] entry_fingerprint;
    logic [31:0] entry_path_hash;
    logic [31:0] entry_offset;
    logic [6:0]  entry_percent;
    logic [31:0] entry_sequence;
  } rsp_t;

  // Where a slot write takes its index from.
  typedef enum logic [1:0] {
    WR_HIT  = 2'd0,
    WR_FREE = 2'd1,
    WR_BEST = 2'd2
  } wr_src_e;

  // What the result register is loaded with.
  typedef enum logic [1:0] {
    RSP_FAIL  = 2'd0,
    RSP_CLEAR = 2'd1,
    RSP_READ  = 2'd2,
    RSP_SAVE  = 2'd3
  } rsp_src_e;

  typedef struct packed {
    logic     cap_req;
    logic     clr_all;
    logic     wr_en;
    wr_src_e  wr_src;
    logic     rd_path;
    logic     scan_init;
    logic     scan_step;
    logic     rsp_load;
    rsp_src_e rsp_src;
  } dp_cmd_t;

  typedef struct packed {
    func_e func;
    logic  refuse;
    logic  key_hit;
    logic  path_hit;
    logic  free_avail;
    logic  scan_last;
  } dp_status_t;

endpackage

// ----- sv/lkst_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_ctrl: controller of the LRU keyed slot table
// Sequences each transaction through evaluation, the optional victim scan
// and the slot write, and raises the result strobe.
// ----------------------------------------------------------------------------
module lkst_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  output logic                   done_o,
  input  lkst_pkg::dp_status_t   status_i,
  output lkst_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_WRITE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d           = state_q;
    cmd_o             = '0;
    cmd_o.wr_src      = lkst_pkg::WR_HIT;
    cmd_o.rsp_src     = lkst_pkg::RSP_FAIL;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.cap_req = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        state_d = S_IDLE;
        case (status_i.func)
          lkst_pkg::FUNC_LOOKUP_KEY: begin
            cmd_o.rsp_load = 1'b1;
            cmd_o.rsp_src  = status_i.key_hit ? lkst_pkg::RSP_READ : lkst_pkg::RSP_FAIL;
          end
          lkst_pkg::FUNC_LOOKUP_PATH: begin
            cmd_o.rd_path  = 1'b1;
            cmd_o.rsp_load = 1'b1;
            cmd_o.rsp_src  = status_i.path_hit ? lkst_pkg::RSP_READ : lkst_pkg::RSP_FAIL;
          end
          lkst_pkg::FUNC_SAVE: begin
            if (status_i.refuse) begin
              cmd_o.rsp_load = 1'b1;
            end else if (status_i.key_hit || status_i.free_avail) begin
              cmd_o.wr_en    = 1'b1;
              cmd_o.wr_src   = status_i.key_hit ? lkst_pkg::WR_HIT : lkst_pkg::WR_FREE;
              cmd_o.rsp_load = 1'b1;
              cmd_o.rsp_src  = lkst_pkg::RSP_SAVE;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: begin
            cmd_o.clr_all  = 1'b1;
            cmd_o.rsp_load = 1'b1;
            cmd_o.rsp_src  = lkst_pkg::RSP_CLEAR;
          end
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_src   = lkst_pkg::WR_BEST;
        cmd_o.rsp_load = 1'b1;
        cmd_o.rsp_src  = lkst_pkg::RSP_SAVE;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.rsp_load;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ----- sv/lkst_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkst_datapath: slot storage and search logic of the LRU keyed slot table
// Holds the slots with their valid bits, compares all keys and path hashes
// in parallel, scans sequence numbers for the victim, and builds the result.
// ----------------------------------------------------------------------------
module lkst_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lkst_pkg::req_t         req_i,
  input  lkst_pkg::dp_cmd_t      cmd_i,
  output lkst_pkg::dp_status_t   status_o,
  output lkst_pkg::rsp_t         rsp_o
);

  lkst_pkg::req_t        req_q;
  logic [lkst_pkg::SLOTS-1:0] valid_q;
  logic [63:0]           key_q  [lkst_pkg::SLOTS];
  logic [31:0]           path_q [lkst_pkg::SLOTS];
  logic [31:0]           pos_q  [lkst_pkg::SLOTS];
  logic [6:0]            prog_q [lkst_pkg::SLOTS];
  logic [31:0]           ord_q  [lkst_pkg::SLOTS];
  logic [31:0]           next_seq_q;

  lkst_pkg::idx_t        cnt_q, best_idx_q;
  logic [31:0]           best_ord_q;
  lkst_pkg::rsp_t        rsp_q, rsp_d;

  logic [lkst_pkg::SLOTS-1:0] key_match, path_match;
  lkst_pkg::idx_t        key_idx, path_idx, free_idx, wr_idx, rd_idx;
  logic                  key_hit, path_hit, free_avail;

  // Parallel compare of every slot; the lowest matching index wins.
  always_comb begin
    key_hit    = 1'b0;
    path_hit   = 1'b0;
    free_avail = 1'b0;
    key_idx    = '0;
    path_idx   = '0;
    free_idx   = '0;
    for (int i = lkst_pkg::SLOTS - 1; i >= 0; i--) begin
      key_match[i]  = valid_q[i] && (key_q[i] == req_q.fingerprint);
      path_match[i] = valid_q[i] && (path_q[i] == req_q.path_hash);
      if (key_match[i]) begin
        key_hit = 1'b1;
        key_idx = lkst_pkg::IDX_W'(i);
      end
      if (path_match[i]) begin
        path_hit = 1'b1;
        path_idx = lkst_pkg::IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_avail = 1'b1;
        free_idx   = lkst_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    status_o.func       = req_q.func;
    status_o.refuse     = (req_q.fingerprint == 64'd0) || req_q.path_empty;
    status_o.key_hit    = key_hit;
    status_o.path_hit   = path_hit;
    status_o.free_avail = free_avail;
    status_o.scan_last  = (cnt_q == lkst_pkg::IDX_W'(lkst_pkg::SLOTS - 1));
  end

  always_comb begin
    case (cmd_i.wr_src)
      lkst_pkg::WR_HIT:  wr_idx = key_idx;
      lkst_pkg::WR_FREE: wr_idx = free_idx;
      default:           wr_idx = best_idx_q;
    endcase
  end

  // The single read port serves the victim scan and the lookups.
  assign rd_idx = cmd_i.scan_step ? cnt_q : (cmd_i.rd_path ? path_idx : key_idx);

  always_comb begin
    rsp_d = '0;
    case (cmd_i.rsp_src)
      lkst_pkg::RSP_CLEAR: begin
        rsp_d.ok = 1'b1;
      end
      lkst_pkg::RSP_READ: begin
        rsp_d.ok                = 1'b1;
        rsp_d.slot_index        = 4'(rd_idx);
        rsp_d.entry_fingerprint = key_q[rd_idx];
        rsp_d.entry_path_hash   = path_q[rd_idx];
        rsp_d.entry_offset      = pos_q[rd_idx];
        rsp_d.entry_percent     = prog_q[rd_idx];
        rsp_d.entry_sequence    = ord_q[rd_idx];
      end
      lkst_pkg::RSP_SAVE: begin
        // The written slot holds exactly the request fields and the
        // sequence number taken at this edge.
        rsp_d.ok                = 1'b1;
        rsp_d.slot_index        = 4'(wr_idx);
        rsp_d.entry_fingerprint = req_q.fingerprint;
        rsp_d.entry_path_hash   = req_q.path_hash;
        rsp_d.entry_offset      = req_q.offset;
        rsp_d.entry_percent     = req_q.percent;
        rsp_d.entry_sequence    = next_seq_q;
      end
      default: begin
        rsp_d.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      next_seq_q <= 32'd1;
    end else if (cmd_i.clr_all) begin
      valid_q    <= '0;
      next_seq_q <= 32'd1;
    end else if (cmd_i.wr_en) begin
      valid_q[wr_idx] <= 1'b1;
      next_seq_q      <= next_seq_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_req) begin
      req_q <= req_i;
    end
    if (cmd_i.wr_en) begin
      key_q[wr_idx]  <= req_q.fingerprint;
      path_q[wr_idx] <= req_q.path_hash;
      pos_q[wr_idx]  <= req_q.offset;
      prog_q[wr_idx] <= req_q.percent;
      ord_q[wr_idx]  <= next_seq_q;
    end
    if (cmd_i.scan_init) begin
      cnt_q      <= '0;
      best_idx_q <= '0;
      best_ord_q <= '1;
    end else if (cmd_i.scan_step) begin
      cnt_q <= cnt_q + lkst_pkg::IDX_W'(1);
      if (ord_q[rd_idx] < best_ord_q) begin
        best_idx_q <= cnt_q;
        best_ord_q <= ord_q[rd_idx];
      end
    end
    if (cmd_i.rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ----- sv/lru_keyed_slot_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_keyed_slot_table_top: LRU keyed slot table
// A table of slots keyed by a 64-bit fingerprint with lookup, save with
// least-recently-saved replacement, and clear.
// ----------------------------------------------------------------------------
// A transaction is accepted on a clock edge where start is high and busy is
// low. Exactly one result follows for each transaction: it is presented on
// rsp_o for a single cycle while done_o is high, and since the receiver cannot
// stall, it must be captured in that cycle. Lookups, clears, refused saves and
// saves that hit an existing key or find a free slot are answered from the
// evaluate state, and the next transaction may be accepted in the same cycle
// as the result strobe. A save of a new key into a full table passes on from
// the evaluate state through the scan and write states, because the victim
// with the lowest sequence number is found by scanning the sequence numbers
// one slot per cycle through the single read port of the slot storage. Keys
// and path hashes are compared against all slots at once. Each slot carries a
// valid bit, so reset and clear take effect with no clearing pass; a zero
// fingerprint never matches, and a save with a zero fingerprint or an empty
// path is refused with ok low and all other result fields zero.
// ----------------------------------------------------------------------------
module lru_keyed_slot_table_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  lkst_pkg::req_t   req_i,
  output logic             done_o,
  output lkst_pkg::rsp_t   rsp_o
);

  lkst_pkg::dp_cmd_t    cmd;
  lkst_pkg::dp_status_t status;

  // The controller owns the sequencing and the result strobe.
  lkst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .done_o   (done_o),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // The datapath holds the slots and builds each result.
  lkst_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

  // A result is only strobed once the controller is back to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result strobed while busy");

  // An accepted transaction always makes the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // Each transaction yields one single-cycle result.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // A failed transaction reports zero in its slot and entry fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (done_o && !rsp_o.ok) |-> (rsp_o.slot_index == 4'd0 &&
                                 rsp_o.entry_fingerprint == 64'd0 &&
                                 rsp_o.entry_sequence == 32'd0))
    else $error("failed result carries nonzero fields");

endmodule
